### hdl/dtw_pkg.sv
// Shared types and constants for the DTW cost accumulator.
// Used by dtw_cell_update, dtw_cost_accumulator and dtw_checker; no dependencies.
`default_nettype none

package dtw_pkg;

  // Parameter defaults
  localparam int MAX_COLS_DEF    = 1024;
  localparam int VALUE_WIDTH_DEF = 48;

  // Fixed field widths
  localparam int COST_W     = 16;
  localparam int OUT_W      = 48;
  localparam int ROW_W      = 16;
  localparam int COL_CFG_W  = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'd1;

  // Register reset values
  localparam logic [ROW_W-1:0]     ROW_COUNT_RST    = 16'd2;
  localparam logic [COL_CFG_W-1:0] COLUMN_COUNT_RST = 11'd2;

  // Infinity marks of the three neighbors of a cell
  typedef struct packed {
    logic up_inf;
    logic left_inf;
    logic diag_inf;
  } nbr_flags_t;

endpackage

`default_nettype wire

### hdl/dtw_cell_update.sv
// Cell recurrence: min of up+cost, left+cost, diag+2*cost with saturation.
// Depends on dtw_pkg for the cost width and the neighbor flag struct.
`default_nettype none

module dtw_cell_update #(
  parameter int VALUE_WIDTH = dtw_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic [dtw_pkg::COST_W-1:0] cost,
  input  wire logic [VALUE_WIDTH-1:0]     up_value,
  input  wire logic [VALUE_WIDTH-1:0]     left_value,
  input  wire logic [VALUE_WIDTH-1:0]     diag_value,
  input  wire dtw_pkg::nbr_flags_t        flags,
  output logic      [VALUE_WIDTH-1:0]     best_value
);

  localparam logic [VALUE_WIDTH-1:0] ValueMax = {VALUE_WIDTH{1'b1}};

  logic [VALUE_WIDTH:0]   sum_up;
  logic [VALUE_WIDTH:0]   sum_left;
  logic [VALUE_WIDTH:0]   sum_diag;
  logic [VALUE_WIDTH-1:0] cand_up;
  logic [VALUE_WIDTH-1:0] cand_left;
  logic [VALUE_WIDTH-1:0] cand_diag;
  logic [dtw_pkg::COST_W:0] cost2;

  // Saturating candidate sums
  assign cost2    = {cost, 1'b0};
  assign sum_up   = {1'b0, up_value}   + (VALUE_WIDTH+1)'(cost);
  assign sum_left = {1'b0, left_value} + (VALUE_WIDTH+1)'(cost);
  assign sum_diag = {1'b0, diag_value} + (VALUE_WIDTH+1)'(cost2);

  assign cand_up   = sum_up[VALUE_WIDTH]   ? ValueMax : sum_up[VALUE_WIDTH-1:0];
  assign cand_left = sum_left[VALUE_WIDTH] ? ValueMax : sum_left[VALUE_WIDTH-1:0];
  assign cand_diag = sum_diag[VALUE_WIDTH] ? ValueMax : sum_diag[VALUE_WIDTH-1:0];

  // Pick the minimum; earlier candidate keeps ties, infinite ones drop out
  always_comb begin
    logic best_inf;
    best_inf   = 1'b1;
    best_value = '0;
    if (!flags.up_inf) begin
      best_value = cand_up;
      best_inf   = 1'b0;
    end
    if (!flags.left_inf && (best_inf || cand_left < best_value)) begin
      best_value = cand_left;
      best_inf   = 1'b0;
    end
    if (!flags.diag_inf && (best_inf || cand_diag < best_value)) begin
      best_value = cand_diag;
      best_inf   = 1'b0;
    end
    if (best_inf) begin
      best_value = ValueMax;
    end
  end

endmodule

`default_nettype wire

### hdl/dtw_cost_accumulator.sv
// The cost is registered in the compute stage and the result in the output register; one result
// per input. Throughput: one cell per cycle while out_tready does not stall the output; the
// previous-row buffer is read on input transfer and written when the cell leaves the compute
// stage, with a bypass for 1-column rows. Reset (rst_n low, synchronous): registers to 2/2,
// grid restarts at cell (1,1), pipeline empty. The row buffer is not cleared; row 1 ignores it.
`default_nettype none

module dtw_cost_accumulator #(
  parameter int MAX_COLS    = dtw_pkg::MAX_COLS_DEF,
  parameter int VALUE_WIDTH = dtw_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [dtw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dtw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // cost stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [dtw_pkg::COST_W-1:0]      in_tdata,   // [15:0] cell_cost
  // cell value stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [dtw_pkg::OUT_W-1:0]       out_tdata,  // [47:0] cell_value
  output logic                                 out_tlast,  // row_end
  output logic                                 out_tuser   // [0] final_cell
);

  localparam int AW = $clog2(MAX_COLS);

  // configuration
  logic [dtw_pkg::ROW_W-1:0]     row_count_r;
  logic [dtw_pkg::COL_CFG_W-1:0] column_count_r;
  logic [31:0]                   rows_eff;
  logic [31:0]                   cols_eff;

  // grid position of the next input
  logic [AW-1:0]             col_r;
  logic [dtw_pkg::ROW_W-1:0] row_r;
  logic                      first_row_r;
  logic                      row_end_new;
  logic                      final_new;

  // compute stage
  logic                        a_valid_r;
  logic [dtw_pkg::COST_W-1:0]  a_cost_r;
  logic [AW-1:0]               a_col_r;
  logic                        a_up_inf_r;
  logic                        a_left_inf_r;
  logic                        a_row_end_r;
  logic                        a_final_r;
  logic                        byp_r;
  logic [VALUE_WIDTH-1:0]      byp_val_r;
  logic [VALUE_WIDTH-1:0]      rd_q_r;
  logic [VALUE_WIDTH-1:0]      left_r;
  logic [VALUE_WIDTH-1:0]      diag_r;
  logic                        diag_inf_r;
  logic [VALUE_WIDTH-1:0]      up_value;
  logic [VALUE_WIDTH-1:0]      best;
  logic [63:0]                 best_w;
  dtw_pkg::nbr_flags_t         flags;
  logic                        adv;
  logic                        in_acc;

  // output register
  logic                        out_valid_r;
  logic [dtw_pkg::OUT_W-1:0]   out_data_r;
  logic                        out_last_r;
  logic                        out_user_r;

  // previous-row buffer
  logic [VALUE_WIDTH-1:0] row_mem [MAX_COLS];

  // Clamp the registers to their working ranges
  always_comb begin
    rows_eff = (row_count_r < 16'd2) ? 32'd2 : 32'(row_count_r);
    if (column_count_r < 11'd2) begin
      cols_eff = 32'd2;
    end else if (32'(column_count_r) > 32'(MAX_COLS)) begin
      cols_eff = 32'(MAX_COLS);
    end else begin
      cols_eff = 32'(column_count_r);
    end
  end

  assign row_end_new = 32'(col_r) >= (cols_eff - 32'd1);
  assign final_new   = row_end_new && (32'(row_r) >= (rows_eff - 32'd1));

  // Handshake
  assign adv       = a_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !a_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= dtw_pkg::ROW_COUNT_RST;
      column_count_r <= dtw_pkg::COLUMN_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dtw_pkg::CFG_ROW_COUNT:    row_count_r    <= cfg_wdata;
        dtw_pkg::CFG_COLUMN_COUNT: column_count_r <= cfg_wdata[dtw_pkg::COL_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the grid position on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= AW'(1);
      row_r       <= dtw_pkg::ROW_W'(1);
      first_row_r <= 1'b1;
    end else if (in_acc) begin
      if (final_new) begin
        col_r       <= AW'(1);
        row_r       <= dtw_pkg::ROW_W'(1);
        first_row_r <= 1'b1;
      end else if (row_end_new) begin
        col_r       <= AW'(1);
        row_r       <= row_r + dtw_pkg::ROW_W'(1);
        first_row_r <= 1'b0;
      end else begin
        col_r       <= col_r + AW'(1);
      end
    end
  end

  // Load the compute stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_acc) begin
      a_valid_r <= 1'b1;
    end else if (adv) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_cost_r     <= in_tdata;
      a_col_r      <= col_r;
      a_up_inf_r   <= first_row_r;
      a_left_inf_r <= (col_r <= AW'(1));
      a_row_end_r  <= row_end_new;
      a_final_r    <= final_new;
      // forward a value written in the same cycle to the same column
      byp_r        <= adv && (a_col_r == col_r);
      byp_val_r    <= best;
    end
  end

  // Row buffer: write the finished cell, read the up neighbor of the next one
  always_ff @(posedge clk) begin
    if (adv) begin
      row_mem[a_col_r] <= best;
    end
    if (in_acc) begin
      rd_q_r <= row_mem[col_r];
    end
  end

  assign up_value = byp_r ? byp_val_r : rd_q_r;
  assign flags    = '{up_inf: a_up_inf_r, left_inf: a_left_inf_r, diag_inf: diag_inf_r};

  dtw_cell_update #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_cell (
    .cost       (a_cost_r),
    .up_value   (up_value),
    .left_value (left_r),
    .diag_value (diag_r),
    .flags      (flags),
    .best_value (best)
  );

  // Update left and diagonal neighbors as the cell leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diag_r     <= '0;
      diag_inf_r <= 1'b0;
    end else if (adv) begin
      if (a_final_r) begin
        diag_r     <= '0;
        diag_inf_r <= 1'b0;
      end else if (a_row_end_r) begin
        diag_r     <= '0;
        diag_inf_r <= 1'b1;
      end else begin
        diag_r     <= up_value;
        diag_inf_r <= a_up_inf_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      left_r <= best;
    end
  end

  // Output register
  assign best_w = 64'(best);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= best_w[dtw_pkg::OUT_W-1:0];
      out_last_r <= a_row_end_r;
      out_user_r <= a_final_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

### hdl/dtw_checker.sv
// Port-level checks for dtw_cost_accumulator, attached by bind.
// Depends on dtw_pkg for port widths.
`default_nettype none

module dtw_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [dtw_pkg::OUT_W-1:0]      out_tdata,
  input wire logic                           out_tlast,
  input wire logic                           out_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // the final cell always closes a row
  a_final_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("final cell without row end");

  // a new result follows an input transfer through the compute stage and the output register
  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without input transfer");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind dtw_cost_accumulator dtw_checker u_dtw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire

### tb/tb_dtw_cost_accumulator.sv
// Self-checking testbench for dtw_cost_accumulator: streams interior-cell costs,
// predicts every accumulated cell value with a scoreboard class. Needs dtw_pkg and the RTL.
`timescale 1ns / 1ps

module tb_dtw_cost_accumulator;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned ITEM_TARGET = 1150;
  localparam logic [dtw_pkg::OUT_W-1:0] VALUE_MAX = {dtw_pkg::OUT_W{1'b1}};

  typedef logic [dtw_pkg::COST_W-1:0]     cost_t;
  typedef logic [dtw_pkg::CFG_DATA_W-1:0] cfg_data_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [dtw_pkg::CFG_IDX_W-1:0] cfg_index = dtw_pkg::CFG_ROW_COUNT;
  logic [dtw_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [dtw_pkg::COST_W-1:0] in_tdata = '0;  // [15:0] cell_cost
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [dtw_pkg::OUT_W-1:0] out_tdata;       // [47:0] cell_value
  logic out_tlast;                            // row_end
  logic out_tuser;                            // [0] final_cell

  typedef struct {
    logic [dtw_pkg::OUT_W-1:0] value;
    logic row_end;
    logic final_cell;
  } cell_result_t;

  // Grid predictor plus the queue of cell values still owed by the block
  class cell_value_scoreboard;
    logic [dtw_pkg::ROW_W-1:0] row_count;
    logic [dtw_pkg::COL_CFG_W-1:0] column_count;
    logic [dtw_pkg::OUT_W-1:0] prev_row [dtw_pkg::MAX_COLS_DEF];
    logic [dtw_pkg::OUT_W-1:0] left_val;
    logic [dtw_pkg::OUT_W-1:0] diag_val;
    bit diag_inf;
    int unsigned col_pos;
    int unsigned row_pos;
    bit first_row;
    cell_result_t expected_cells[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned grids;

    function new();
      row_count = dtw_pkg::ROW_COUNT_RST;
      column_count = dtw_pkg::COLUMN_COUNT_RST;
      errors = 0;
      checked = 0;
      grids = 0;
      restart_grid();
    endfunction

    function void restart_grid();
      left_val = '0;
      diag_val = '0;
      diag_inf = 1'b0;
      col_pos = 1;
      row_pos = 1;
      first_row = 1'b1;
    endfunction

    function void write_reg(logic [dtw_pkg::CFG_IDX_W-1:0] idx,
                            logic [dtw_pkg::CFG_DATA_W-1:0] val);
      if (idx == dtw_pkg::CFG_ROW_COUNT) row_count = val[dtw_pkg::ROW_W-1:0];
      else if (idx == dtw_pkg::CFG_COLUMN_COUNT) column_count = val[dtw_pkg::COL_CFG_W-1:0];
    endfunction

    function int unsigned eff_rows();
      return (row_count < 2) ? 2 : row_count;
    endfunction

    function int unsigned eff_cols();
      int unsigned c;
      c = (column_count < 2) ? 2 : column_count;
      return (c > dtw_pkg::MAX_COLS_DEF) ? dtw_pkg::MAX_COLS_DEF : c;
    endfunction

    function bit at_grid_start();
      return first_row && col_pos == 1 && row_pos == 1;
    endfunction

    function int unsigned pending();
      return expected_cells.size();
    endfunction

    function logic [dtw_pkg::OUT_W-1:0] sat_add(logic [dtw_pkg::OUT_W-1:0] a,
                                                logic [dtw_pkg::OUT_W-1:0] b);
      logic [dtw_pkg::OUT_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[dtw_pkg::OUT_W] ? VALUE_MAX : sum[dtw_pkg::OUT_W-1:0];
    endfunction

    // Accumulate one cell from its accepted cost; returns 1 on the final cell
    function bit note_cost(logic [dtw_pkg::COST_W-1:0] cost);
      logic [dtw_pkg::OUT_W-1:0] up_val, best, cand;
      bit up_inf, best_inf, row_end, grid_end;
      int unsigned col;
      cell_result_t r;
      col = (col_pos >= dtw_pkg::MAX_COLS_DEF) ? dtw_pkg::MAX_COLS_DEF - 1 : col_pos;
      up_inf = first_row;
      up_val = up_inf ? '0 : prev_row[col];
      best_inf = 1'b1;
      best = '0;
      // candidates in priority order: up, left, diagonal; strict less-than keeps ties early
      if (!up_inf) begin
        best = sat_add(up_val, {32'd0, cost});
        best_inf = 1'b0;
      end
      if (col > 1) begin
        cand = sat_add(left_val, {32'd0, cost});
        if (best_inf || cand < best) begin
          best = cand;
          best_inf = 1'b0;
        end
      end
      if (!diag_inf) begin
        cand = sat_add(diag_val, {31'd0, cost, 1'b0});
        if (best_inf || cand < best) begin
          best = cand;
          best_inf = 1'b0;
        end
      end
      if (best_inf) best = VALUE_MAX;
      row_end = (col >= eff_cols() - 1);
      grid_end = row_end && (row_pos >= eff_rows() - 1);
      r.value = best;
      r.row_end = row_end;
      r.final_cell = grid_end;
      expected_cells.insert(expected_cells.size(), r);

      // the up neighbor of this cell is the diagonal of the next one
      diag_val = up_val;
      diag_inf = up_inf;
      left_val = best;
      prev_row[col] = best;
      if (grid_end) begin
        restart_grid();
        grids++;
      end else if (row_end) begin
        col_pos = 1;
        row_pos++;
        first_row = 1'b0;
        diag_inf = 1'b1;
        diag_val = '0;
      end else begin
        col_pos = col + 1;
      end
      return grid_end;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Compare one cell transfer against the oldest prediction
    task check_cell(logic [dtw_pkg::OUT_W-1:0] value, logic row_end, logic final_cell);
      cell_result_t e;
      if (expected_cells.size() == 0) begin
        report($sformatf("cell value %0d with no cost outstanding", value));
        return;
      end
      e = expected_cells.pop_front();
      checked++;
      if (value !== e.value)
        report($sformatf("cell %0d: value %0d, expected %0d", checked, value, e.value));
      if (row_end !== e.row_end)
        report($sformatf("cell %0d: row_end %b, expected %b", checked, row_end, e.row_end));
      if (final_cell !== e.final_cell)
        report($sformatf("cell %0d: final_cell %b, expected %b", checked, final_cell,
                         e.final_cell));
    endtask
  endclass

  cell_value_scoreboard sb;
  bit src_burst = 1'b0;
  bit sink_burst = 1'b0;
  bit hold_req = 1'b0;
  int unsigned holds_done = 0;
  int unsigned costs_sent = 0;
  int unsigned cfg_changes = 0;
  int unsigned mid_changes = 0;
  int unsigned input_stalls = 0;

  dtw_cost_accumulator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Check every cell value transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready)
      sb.check_cell(out_tdata, out_tlast, out_tuser);
  end

  // Count cycles where the block pushes back on the cost stream
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready !== 1'b1) input_stalls++;
  end

  // Receiver: random stalls, bursts of full rate, and one long hold-off on request
  initial begin : receiver
    int unsigned stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end
      if ($urandom_range(0, 19) == 0) sink_burst = !sink_burst;
      stall = sink_burst ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  function automatic cost_t pick_cost();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return cost_t'($urandom_range(0, 3));  // small costs make ties likely
      4:          return '0;
      5:          return '1;
      default:    return cost_t'($urandom);
    endcase
  endfunction

  function automatic cfg_data_t pick_rows();
    case ($urandom_range(0, 19))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3, 4:    return cfg_data_t'($urandom_range(9, 200));
      default: return cfg_data_t'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic cfg_data_t pick_cols();
    case ($urandom_range(0, 19))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd1024;
      3:       return cfg_data_t'($urandom);  // upper bits drop, may land past the clamp
      default: return cfg_data_t'($urandom_range(2, 12));
    endcase
  endfunction

  // Offer one cost after a random gap, hold until transfer, then predict it
  task automatic send_cost(input logic [dtw_pkg::COST_W-1:0] cost, output bit fin);
    int unsigned gap;
    if ($urandom_range(0, 19) == 0) src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      in_tdata <= cost_t'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= cost;
    do @(posedge clk); while (in_tready !== 1'b1);
    fin = sb.note_cost(cost);
    costs_sent++;
  endtask

  task automatic run_part(input int unsigned cap, output int unsigned sent);
    bit fin;
    sent = 0;
    fin = 1'b0;
    while (!fin && sent < cap) begin
      send_cost(pick_cost(), fin);
      sent++;
    end
  endtask

  // Drain the block, then write both size registers
  task automatic reconfig(input logic [dtw_pkg::CFG_DATA_W-1:0] rows,
                          input logic [dtw_pkg::CFG_DATA_W-1:0] cols);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_changes++;
    if (!sb.at_grid_start()) mid_changes++;
    cfg_we <= 1'b1;
    cfg_index <= dtw_pkg::CFG_ROW_COUNT;
    cfg_wdata <= rows;
    @(posedge clk);
    sb.write_reg(dtw_pkg::CFG_ROW_COUNT, rows);
    cfg_index <= dtw_pkg::CFG_COLUMN_COUNT;
    cfg_wdata <= cols;
    @(posedge clk);
    sb.write_reg(dtw_pkg::CFG_COLUMN_COUNT, cols);
    cfg_we <= 1'b0;
    cfg_wdata <= cfg_data_t'($urandom);
  endtask

  // One random stretch: maybe resize, then stream cells until the grid ends or a cap hits.
  // Columns only grow while the grid is in its first row, so no row ever reads a
  // buffer column that was never written.
  task automatic random_phase(output int unsigned sent);
    logic [dtw_pkg::CFG_DATA_W-1:0] rows, cols;
    int unsigned cur, cap;
    bit big;
    big = sb.eff_cols() > 16 || sb.eff_rows() > 16;
    if (sb.at_grid_start() || big || $urandom_range(0, 3) == 0) begin
      rows = pick_rows();
      if (sb.first_row) begin
        cols = pick_cols();
      end else begin
        cur = sb.eff_cols();
        cols = cfg_data_t'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 1)
                           : $urandom_range(2, (cur > 12) ? 12 : cur));
      end
      reconfig(rows, cols);
    end
    big = sb.eff_cols() > 16 || sb.eff_rows() > 16;
    if (big || $urandom_range(0, 3) == 0) cap = $urandom_range(1, 30);
    else cap = 150;
    run_part(cap, sent);
  endtask

  initial begin : stimulus
    int unsigned n;
    bit fin;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset sizes give a single interior cell; the second cost starts a fresh grid
    send_cost(16'hFFFF, fin);
    send_cost(16'h0000, fin);

    // 2x3 interior with extreme and small costs
    reconfig(16'd3, 16'd4);
    send_cost(16'hFFFF, fin); send_cost(16'd1, fin);      send_cost(16'hFFFF, fin);
    send_cost(16'd0, fin);    send_cost(16'hFFFF, fin);   send_cost(16'd2, fin);

    // Sizes below the minimum clamp to a single cell
    reconfig(16'd1, 16'd0);
    send_cost(16'hAAAA, fin);
    reconfig(16'd0, 16'd1);
    send_cost(16'h5555, fin);

    // Row count cut below the current row: the next row end closes the grid
    reconfig(16'hFFFF, 16'd3);
    repeat (4) send_cost(pick_cost(), fin);
    reconfig(16'd2, 16'd3);
    run_part(10, n);

    // Column count cut below the current column: the next cell ends its row
    reconfig(16'd4, 16'd6);
    repeat (3) send_cost(pick_cost(), fin);
    reconfig(16'd4, 16'd3);
    run_part(10, n);

    // Widest row (column count past the clamp), streamed at full rate under a long hold-off
    reconfig(16'd2, 16'hFFFF);
    src_burst = 1'b1;
    hold_req = 1'b1;
    run_part(2000, n);

    // Random sizes and mid-grid resizes until the item budget is used up
    while (costs_sent < ITEM_TARGET) begin
      random_phase(n);
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Streamed %0d costs, %0d grids completed, %0d cell values checked",
             costs_sent, sb.grids, sb.checked);
    $display("%0d size changes (%0d mid-grid), %0d hold-offs, %0d input stall cycles, %0d errors",
             cfg_changes, mid_changes, holds_done, input_stalls, sb.errors);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(64'd10_000_000);
    $display("Timeout with %0d cell values outstanding", sb.pending());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
